// ===== hw/rtl/tec_pkg.sv =====
// Shared types, constants and a helper function for the touch event qualifier.
// Used by tec_front, tec_div, tec_back and touch_event_qualifier_unit.
`timescale 1ns / 1ps
`default_nettype none
package tec_pkg;

  localparam int TEC_QUEUE_DEPTH = 2;
  // Dividend width of the mapping divider; two quotient bits are resolved per cycle.
  localparam int DIV_W   = 24;
  localparam int RAW_W   = 12;
  localparam int COORD_W = 11;
  localparam int CFG_W   = 16;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_DOWN = 2'd1;
  localparam logic [1:0] KIND_MOVE = 2'd2;
  localparam logic [1:0] KIND_UP   = 2'd3;

  typedef enum logic [2:0] {
    CFG_RAW_MIN_X,
    CFG_RAW_MAX_X,
    CFG_RAW_MIN_Y,
    CFG_RAW_MAX_Y,
    CFG_SCREEN_WIDTH,
    CFG_SCREEN_HEIGHT,
    CFG_MOVE_THRESHOLD,
    CFG_RELEASE_DEBOUNCE
  } tec_cfg_idx_t;

  typedef enum logic [1:0] {
    CLS_ACTIVITY,
    CLS_CONTACT,
    CLS_NO_CONTACT
  } tec_cls_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } tec_state_t;

  typedef struct packed {
    logic              op;
    logic              touched;
    logic [RAW_W-1:0]  raw_x;
    logic [RAW_W-1:0]  raw_y;
    logic [31:0]       now_ms;
  } tec_in_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [31:0]        inactive_ms;
  } tec_out_t;

  typedef struct packed {
    tec_cls_t          cls;
    logic [RAW_W-1:0]  raw_x;
    logic [RAW_W-1:0]  raw_y;
    logic [31:0]       now_ms;
  } tec_cmd_t;

  // Largest valid coordinate for a panel size: size 0 counts as 1, sizes above 2048 as 2048.
  function automatic logic [COORD_W-1:0] size_limit(input logic [RAW_W-1:0] size);
    logic [RAW_W-1:0] s;
    begin
      s = size;
      if (s == '0) begin
        s = RAW_W'(1);
      end else if (s > RAW_W'(2048)) begin
        s = RAW_W'(2048);
      end
      size_limit = COORD_W'(s - RAW_W'(1));
    end
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/tec_front.sv =====
// Front end: classifies each accepted item and holds it in a short queue.
// Depends on tec_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tec_front #(
  parameter int DEPTH = tec_pkg::TEC_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tec_pkg::tec_in_t  in_data,
  output logic              cmd_valid,
  output tec_pkg::tec_cmd_t cmd,
  input  logic              cmd_pop
);
  import tec_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tec_cmd_t           mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  tec_cmd_t           entry;
  logic               push;

  always_comb begin
    entry.raw_x  = in_data.raw_x;
    entry.raw_y  = in_data.raw_y;
    entry.now_ms = in_data.now_ms;
    if (in_data.op) begin
      entry.cls = CLS_ACTIVITY;
    end else if (in_data.touched) begin
      entry.cls = CLS_CONTACT;
    end else begin
      entry.cls = CLS_NO_CONTACT;
    end
  end

  assign in_stall  = (count_r == CNT_W'(DEPTH));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (count_r != '0);
  assign cmd       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (cmd_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !cmd_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (!push && cmd_pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= entry;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tec_div.sv =====
// Iterative unsigned divider, two quotient bits per cycle, for the coordinate mapping.
// Depends on tec_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tec_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [tec_pkg::DIV_W-1:0] dividend,
  input  logic [tec_pkg::RAW_W-1:0] divisor,
  output logic                      busy,
  output logic [tec_pkg::DIV_W-1:0] quotient
);
  import tec_pkg::*;

  localparam int STEPS = DIV_W / 2;
  localparam int CNT_W = $clog2(STEPS);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [RAW_W-1:0] rem_r, rem_nxt;
  logic [RAW_W-1:0] div_r;
  logic [DIV_W-1:0] dvd_r, dvd_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [RAW_W:0]   r1, r1s, r2, r2s;
  logic             b1, b2;

  // Two restoring steps; for a nonzero divisor the partial remainder stays below the divisor.
  always_comb begin
    r1  = {rem_r, dvd_r[DIV_W-1]};
    b1  = (r1 >= {1'b0, div_r});
    r1s = b1 ? (r1 - {1'b0, div_r}) : r1;
    r2  = {r1s[RAW_W-1:0], dvd_r[DIV_W-2]};
    b2  = (r2 >= {1'b0, div_r});
    r2s = b2 ? (r2 - {1'b0, div_r}) : r2;
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(STEPS - 1);
      rem_nxt  = '0;
      dvd_nxt  = dividend;
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = r2s[RAW_W-1:0];
      dvd_nxt = {dvd_r[DIV_W-3:0], 2'b00};
      quo_nxt = {quo_r[DIV_W-3:0], b1, b2};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      div_r <= divisor;
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// ===== hw/rtl/tec_back.sv =====
// Back end: configuration registers, touch state, coordinate mapping and result register.
// Depends on tec_pkg and tec_div.
`timescale 1ns / 1ps
`default_nettype none
module tec_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_idx,
  input  logic [tec_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      cmd_valid,
  input  tec_pkg::tec_cmd_t         cmd,
  output logic                      cmd_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output tec_pkg::tec_out_t         out_data
);
  import tec_pkg::*;

  // Configuration
  logic [RAW_W-1:0] min_x_r, max_x_r, min_y_r, max_y_r;
  logic [RAW_W-1:0] width_r, height_r;
  logic [7:0]       thresh_r;
  logic [15:0]      debounce_r;

  // Touch state
  logic               pressed_r, pressed_nxt;
  logic               pending_r, pending_nxt;
  logic [31:0]        rel_time_r, rel_time_nxt;
  logic [31:0]        act_time_r, act_time_nxt;
  logic [COORD_W-1:0] last_col_r, last_col_nxt;
  logic [COORD_W-1:0] last_row_r, last_row_nxt;

  // Sequencer and mapping work registers
  tec_state_t         st_r, st_nxt;
  tec_cmd_t           cur_r;
  logic               neg_x_r, neg_y_r, zero_x_r, zero_y_r;
  logic [COORD_W-1:0] lim_x_r, lim_y_r;

  logic               out_valid_r, out_valid_nxt;
  tec_out_t           out_r, out_nxt;

  logic               out_free, commit_simple, commit_touch, latch_cmd, div_start;
  logic               busy_x, busy_y;
  logic [DIV_W-1:0]   quo_x, quo_y, prod_x, prod_y;
  logic [RAW_W:0]     num_x, num_y, den_x, den_y;
  logic [RAW_W-1:0]   anum_x, anum_y, aden_x, aden_y;
  logic [COORD_W-1:0] lim_x, lim_y, map_x, map_y, dx, dy;
  logic [31:0]        rel_elapsed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_x_r    <= RAW_W'(200);
      max_x_r    <= RAW_W'(3700);
      min_y_r    <= RAW_W'(240);
      max_y_r    <= RAW_W'(3800);
      width_r    <= RAW_W'(320);
      height_r   <= RAW_W'(240);
      thresh_r   <= 8'd4;
      debounce_r <= 16'd40;
    end else if (cfg_we) begin
      case (tec_cfg_idx_t'(cfg_idx))
        CFG_RAW_MIN_X:        min_x_r    <= cfg_wdata[RAW_W-1:0];
        CFG_RAW_MAX_X:        max_x_r    <= cfg_wdata[RAW_W-1:0];
        CFG_RAW_MIN_Y:        min_y_r    <= cfg_wdata[RAW_W-1:0];
        CFG_RAW_MAX_Y:        max_y_r    <= cfg_wdata[RAW_W-1:0];
        CFG_SCREEN_WIDTH:     width_r    <= cfg_wdata[RAW_W-1:0];
        CFG_SCREEN_HEIGHT:    height_r   <= cfg_wdata[RAW_W-1:0];
        CFG_MOVE_THRESHOLD:   thresh_r   <= cfg_wdata[7:0];
        CFG_RELEASE_DEBOUNCE: debounce_r <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  // Next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (cmd_valid && cmd.cls == CLS_CONTACT) begin
          st_nxt = ST_MUL;
        end
      end
      ST_MUL: st_nxt = ST_DIV;
      ST_DIV: begin
        if (!busy_x && !busy_y) begin
          st_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    latch_cmd     = 1'b0;
    commit_simple = 1'b0;
    commit_touch  = 1'b0;
    div_start     = 1'b0;
    case (st_r)
      ST_IDLE: begin
        latch_cmd     = cmd_valid && (cmd.cls == CLS_CONTACT);
        commit_simple = cmd_valid && (cmd.cls != CLS_CONTACT) && out_free;
      end
      ST_MUL:  div_start = 1'b1;
      ST_DIV: begin
      end
      ST_DONE: commit_touch = out_free;
      default: begin
      end
    endcase
  end

  assign cmd_pop = latch_cmd || commit_simple;

  // Signed offset and span in sign-magnitude form; the product feeds the divider register.
  always_comb begin
    lim_x  = size_limit(width_r);
    lim_y  = size_limit(height_r);
    num_x  = {1'b0, cur_r.raw_x} - {1'b0, min_x_r};
    num_y  = {1'b0, cur_r.raw_y} - {1'b0, min_y_r};
    den_x  = {1'b0, max_x_r} - {1'b0, min_x_r};
    den_y  = {1'b0, max_y_r} - {1'b0, min_y_r};
    anum_x = num_x[RAW_W] ? RAW_W'(-num_x) : num_x[RAW_W-1:0];
    anum_y = num_y[RAW_W] ? RAW_W'(-num_y) : num_y[RAW_W-1:0];
    aden_x = den_x[RAW_W] ? RAW_W'(-den_x) : den_x[RAW_W-1:0];
    aden_y = den_y[RAW_W] ? RAW_W'(-den_y) : den_y[RAW_W-1:0];
    prod_x = DIV_W'(anum_x) * DIV_W'(lim_x);
    prod_y = DIV_W'(anum_y) * DIV_W'(lim_y);
  end

  always_ff @(posedge clk) begin
    if (latch_cmd) begin
      cur_r <= cmd;
    end
    if (div_start) begin
      neg_x_r  <= num_x[RAW_W] ^ den_x[RAW_W];
      neg_y_r  <= num_y[RAW_W] ^ den_y[RAW_W];
      zero_x_r <= (den_x == '0);
      zero_y_r <= (den_y == '0);
      lim_x_r  <= lim_x;
      lim_y_r  <= lim_y;
    end
  end

  tec_div u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_x),
    .divisor  (aden_x),
    .busy     (busy_x),
    .quotient (quo_x)
  );

  tec_div u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_y),
    .divisor  (aden_y),
    .busy     (busy_y),
    .quotient (quo_y)
  );

  // A negative quotient or a zero span clamps to zero; a quotient above the limit clamps to it.
  always_comb begin
    if (zero_x_r || neg_x_r) begin
      map_x = '0;
    end else if (quo_x > DIV_W'(lim_x_r)) begin
      map_x = lim_x_r;
    end else begin
      map_x = quo_x[COORD_W-1:0];
    end
    if (zero_y_r || neg_y_r) begin
      map_y = '0;
    end else if (quo_y > DIV_W'(lim_y_r)) begin
      map_y = lim_y_r;
    end else begin
      map_y = quo_y[COORD_W-1:0];
    end
    dx          = (map_x > last_col_r) ? map_x - last_col_r : last_col_r - map_x;
    dy          = (map_y > last_row_r) ? map_y - last_row_r : last_row_r - map_y;
    rel_elapsed = cmd.now_ms - rel_time_r;
  end

  always_comb begin
    pressed_nxt   = pressed_r;
    pending_nxt   = pending_r;
    rel_time_nxt  = rel_time_r;
    act_time_nxt  = act_time_r;
    last_col_nxt  = last_col_r;
    last_row_nxt  = last_row_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (commit_simple) begin
      out_valid_nxt       = 1'b1;
      out_nxt.kind        = KIND_NONE;
      out_nxt.pos_x       = '0;
      out_nxt.pos_y       = '0;
      out_nxt.inactive_ms = cmd.now_ms - act_time_r;
      case (cmd.cls)
        CLS_ACTIVITY: begin
          act_time_nxt        = cmd.now_ms;
          out_nxt.inactive_ms = '0;
        end
        CLS_NO_CONTACT: begin
          if (pressed_r) begin
            if (!pending_r) begin
              pending_nxt  = 1'b1;
              rel_time_nxt = cmd.now_ms;
            end else if (rel_elapsed >= {16'd0, debounce_r}) begin
              pressed_nxt   = 1'b0;
              pending_nxt   = 1'b0;
              out_nxt.kind  = KIND_UP;
              out_nxt.pos_x = last_col_r;
              out_nxt.pos_y = last_row_r;
            end
          end
        end
        default: begin
        end
      endcase
    end else if (commit_touch) begin
      out_valid_nxt       = 1'b1;
      out_nxt.kind        = KIND_NONE;
      out_nxt.pos_x       = '0;
      out_nxt.pos_y       = '0;
      out_nxt.inactive_ms = '0;
      act_time_nxt        = cur_r.now_ms;
      pending_nxt         = 1'b0;
      if (!pressed_r) begin
        pressed_nxt   = 1'b1;
        last_col_nxt  = map_x;
        last_row_nxt  = map_y;
        out_nxt.kind  = KIND_DOWN;
        out_nxt.pos_x = map_x;
        out_nxt.pos_y = map_y;
      end else if (dx >= {3'd0, thresh_r} || dy >= {3'd0, thresh_r}) begin
        last_col_nxt  = map_x;
        last_row_nxt  = map_y;
        out_nxt.kind  = KIND_MOVE;
        out_nxt.pos_x = map_x;
        out_nxt.pos_y = map_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      pressed_r   <= 1'b0;
      pending_r   <= 1'b0;
      rel_time_r  <= '0;
      act_time_r  <= '0;
      last_col_r  <= '0;
      last_row_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      pressed_r   <= pressed_nxt;
      pending_r   <= pending_nxt;
      rel_time_r  <= rel_time_nxt;
      act_time_r  <= act_time_nxt;
      last_col_r  <= last_col_nxt;
      last_row_r  <= last_row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ===== hw/rtl/touch_event_qualifier_unit.sv =====
// Touch event qualifier top level. A contact sample steps through the back end in order
// (queue pop, multiply, division in the two-bit-per-cycle mapping dividers, commit), and
// out_valid rises when the result register loads; a stalled output holds back the commit.
// Activity notes and no-contact samples are committed from the idle state once the output
// is free. The front queue keeps accepting items while the back end divides, until full.
// Synchronous active-low reset loads the default calibration and clears the touch state.
`timescale 1ns / 1ps
`default_nettype none
module touch_event_qualifier_unit #(
  parameter int QUEUE_DEPTH = tec_pkg::TEC_QUEUE_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  tec_pkg::tec_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output tec_pkg::tec_out_t         out_data,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_idx,
  input  logic [tec_pkg::CFG_W-1:0] cfg_wdata
);
  import tec_pkg::*;

  logic     cmd_valid;
  logic     cmd_pop;
  tec_cmd_t cmd;

  tec_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  tec_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== tb/sv/tb_touch_event_qualifier_unit.sv =====
// Self-checking testbench for touch_event_qualifier_unit: a directed table, then random touch
// strokes under several calibrations, with each result checked against the table or a local predictor.
// Depends on tec_pkg for the item types, event kinds and register indexes.
`timescale 1ns / 1ps
module tb_touch_event_qualifier_unit;
  import tec_pkg::*;

  localparam logic OP_POLL     = 1'b0;
  localparam logic OP_ACTIVITY = 1'b1;
  localparam int   SETTLE_CYCLES = 24;
  localparam int   RANDOM_PHASES = 6;
  localparam int   ITEMS_PER_PHASE = 170;

  typedef logic [7:0][15:0] cfg_set_t;

  typedef struct {
    logic     is_cfg;
    cfg_set_t cfg;
    tec_in_t  item;
    logic     has_exp;
    tec_out_t exp;
  } dir_row_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  tec_in_t           in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  tec_out_t          out_data;
  logic              cfg_we = 1'b0;
  logic [2:0]        cfg_idx = '0;
  logic [CFG_W-1:0]  cfg_wdata = '0;

  touch_event_qualifier_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor copy of the calibration and the touch state.
  logic [11:0] cal_min_x, cal_max_x, cal_min_y, cal_max_y, cal_width, cal_height;
  logic [7:0]  cal_threshold;
  logic [15:0] cal_debounce;
  logic        pressed, release_armed;
  logic [31:0] release_start, activity_stamp;
  logic [10:0] last_x, last_y;

  tec_out_t pending_events[$];
  dir_row_t dir_rows[$];
  int       mismatch_count = 0;
  int       send_idle = 0;
  int       recv_idle = 0;
  tec_out_t want;

  // Random stroke generator state.
  logic [31:0] stim_time = '0;
  logic        stroke_on = 1'b0;
  logic [11:0] stroke_x = '0, stroke_y = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic flag_mismatch(input string what, input longint got, input longint exp_val);
    $display("ERROR at %0t: %s: got %0h, expected %0h", $realtime, what, got, exp_val);
    mismatch_count++;
  endtask

  function automatic logic [10:0] map_to_pixels(input logic [11:0] raw, input logic [11:0] lo,
                                                input logic [11:0] hi, input logic [11:0] size);
    longint lim, den, v;
    if (size == 12'd0) lim = 0;
    else if (size > 12'd2048) lim = 2047;
    else lim = longint'(size) - 1;
    den = longint'(hi) - longint'(lo);
    if (den == 0) return '0;
    // Signed 64-bit division truncates toward zero, the same as the mapping requires.
    v = (longint'(raw) - longint'(lo)) * lim / den;
    if (v < 0) return '0;
    if (v > lim) return 11'(lim);
    return 11'(v);
  endfunction

  function automatic logic [10:0] pixel_travel(input logic [10:0] a, input logic [10:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic tec_out_t qualify_sample(input tec_in_t it);
    tec_out_t r;
    logic [10:0] x, y;
    r = '0;
    r.kind = KIND_NONE;
    if (it.op == OP_ACTIVITY) begin
      activity_stamp = it.now_ms;
    end else if (it.touched) begin
      x = map_to_pixels(it.raw_x, cal_min_x, cal_max_x, cal_width);
      y = map_to_pixels(it.raw_y, cal_min_y, cal_max_y, cal_height);
      activity_stamp = it.now_ms;
      release_armed = 1'b0;
      if (!pressed) begin
        pressed = 1'b1;
        last_x = x;
        last_y = y;
        r.kind = KIND_DOWN;
        r.pos_x = x;
        r.pos_y = y;
      end else if (pixel_travel(x, last_x) >= 11'(cal_threshold) ||
                   pixel_travel(y, last_y) >= 11'(cal_threshold)) begin
        last_x = x;
        last_y = y;
        r.kind = KIND_MOVE;
        r.pos_x = x;
        r.pos_y = y;
      end
    end else if (pressed) begin
      if (!release_armed) begin
        release_armed = 1'b1;
        release_start = it.now_ms;
      end else if (32'(it.now_ms - release_start) >= 32'(cal_debounce)) begin
        pressed = 1'b0;
        release_armed = 1'b0;
        r.kind = KIND_UP;
        r.pos_x = last_x;
        r.pos_y = last_y;
      end
    end
    r.inactive_ms = it.now_ms - activity_stamp;
    return r;
  endfunction

  function automatic cfg_set_t default_settings();
    cfg_set_t s;
    s[CFG_RAW_MIN_X]        = 16'd200;
    s[CFG_RAW_MAX_X]        = 16'd3700;
    s[CFG_RAW_MIN_Y]        = 16'd240;
    s[CFG_RAW_MAX_Y]        = 16'd3800;
    s[CFG_SCREEN_WIDTH]     = 16'd320;
    s[CFG_SCREEN_HEIGHT]    = 16'd240;
    s[CFG_MOVE_THRESHOLD]   = 16'd4;
    s[CFG_RELEASE_DEBOUNCE] = 16'd40;
    return s;
  endfunction

  function automatic logic [11:0] random_size();
    case ($urandom_range(0, 5))
      0: return 12'($urandom);
      1: return 12'($urandom_range(0, 1) * 2048);
      default: return 12'($urandom_range(1, 800));
    endcase
  endfunction

  function automatic cfg_set_t random_settings();
    cfg_set_t s;
    logic [11:0] a, b;
    for (int axis = 0; axis < 2; axis++) begin
      case ($urandom_range(0, 5))
        0: begin a = 12'($urandom); b = 12'($urandom); end
        1: begin a = 12'($urandom); b = a; end
        2: begin a = 12'($urandom_range(3000, 4095)); b = 12'($urandom_range(0, 1000)); end
        default: begin a = 12'($urandom_range(0, 1000)); b = 12'($urandom_range(3000, 4095)); end
      endcase
      s[2 * axis]     = 16'(a);
      s[2 * axis + 1] = 16'(b);
    end
    s[CFG_SCREEN_WIDTH]  = 16'(random_size());
    s[CFG_SCREEN_HEIGHT] = 16'(random_size());
    case ($urandom_range(0, 4))
      0: s[CFG_MOVE_THRESHOLD] = 16'($urandom_range(0, 1) * 255);
      1: s[CFG_MOVE_THRESHOLD] = 16'($urandom_range(0, 255));
      default: s[CFG_MOVE_THRESHOLD] = 16'($urandom_range(0, 16));
    endcase
    case ($urandom_range(0, 5))
      0: s[CFG_RELEASE_DEBOUNCE] = 16'($urandom_range(0, 1) * 65535);
      1: s[CFG_RELEASE_DEBOUNCE] = 16'($urandom);
      default: s[CFG_RELEASE_DEBOUNCE] = 16'($urandom_range(0, 200));
    endcase
    return s;
  endfunction

  function automatic tec_in_t next_random_item();
    tec_in_t it;
    int pick;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      9: stim_time = $urandom;
      6, 7, 8: stim_time = stim_time + 32'($urandom_range(0, int'(cal_debounce) + 10));
      default: stim_time = stim_time + 32'($urandom_range(0, int'(cal_debounce) / 4 + 3));
    endcase
    it.op      = OP_POLL;
    it.touched = 1'($urandom);
    it.raw_x   = 12'($urandom);
    it.raw_y   = 12'($urandom);
    it.now_ms  = stim_time;
    if (pick < 8) begin
      it.op = OP_ACTIVITY;
    end else if (pick >= 14) begin
      // Strokes: runs of contact with small travel, then runs without contact.
      if ($urandom_range(0, 9) == 0) stroke_on = ~stroke_on;
      it.touched = stroke_on;
      if (stroke_on && $urandom_range(0, 7) != 0) begin
        stroke_x = stroke_x + 12'($urandom_range(0, 64)) - 12'd32;
        stroke_y = stroke_y + 12'($urandom_range(0, 64)) - 12'd32;
        it.raw_x = stroke_x;
        it.raw_y = stroke_y;
      end else if (stroke_on) begin
        stroke_x = it.raw_x;
        stroke_y = it.raw_y;
      end
    end
    return it;
  endfunction

  function automatic void add_item(input logic op, input logic touched, input logic [11:0] rx,
                                   input logic [11:0] ry, input logic [31:0] now,
                                   input logic chk, input logic [1:0] kind,
                                   input logic [10:0] px, input logic [10:0] py,
                                   input logic [31:0] idle_ms);
    dir_row_t row;
    row.is_cfg = 1'b0;
    row.cfg = '0;
    row.item = '{op: op, touched: touched, raw_x: rx, raw_y: ry, now_ms: now};
    row.has_exp = chk;
    row.exp = '{kind: kind, pos_x: px, pos_y: py, inactive_ms: idle_ms};
    dir_rows.push_back(row);
  endfunction

  function automatic void add_settings(input cfg_set_t s);
    dir_row_t row;
    row.is_cfg = 1'b1;
    row.cfg = s;
    row.item = '0;
    row.has_exp = 1'b0;
    row.exp = '0;
    dir_rows.push_back(row);
  endfunction

  task automatic send_item(input tec_in_t it);
    if ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic apply_settings(input cfg_set_t s);
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    // A contact sample may still be in the dividers; let it finish before writing.
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= 3'(i);
      cfg_wdata <= s[i];
      @(posedge clk);
      case (tec_cfg_idx_t'(i))
        CFG_RAW_MIN_X:        cal_min_x = s[i][11:0];
        CFG_RAW_MAX_X:        cal_max_x = s[i][11:0];
        CFG_RAW_MIN_Y:        cal_min_y = s[i][11:0];
        CFG_RAW_MAX_Y:        cal_max_y = s[i][11:0];
        CFG_SCREEN_WIDTH:     cal_width = s[i][11:0];
        CFG_SCREEN_HEIGHT:    cal_height = s[i][11:0];
        CFG_MOVE_THRESHOLD:   cal_threshold = s[i][7:0];
        CFG_RELEASE_DEBOUNCE: cal_debounce = s[i];
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        flag_mismatch("result with nothing pending", longint'(out_data), 0);
      end else begin
        want = pending_events.pop_front();
        if (out_data.kind != want.kind) flag_mismatch("kind", out_data.kind, want.kind);
        if (out_data.pos_x != want.pos_x) flag_mismatch("pos_x", out_data.pos_x, want.pos_x);
        if (out_data.pos_y != want.pos_y) flag_mismatch("pos_y", out_data.pos_y, want.pos_y);
        if (out_data.inactive_ms != want.inactive_ms)
          flag_mismatch("inactive_ms", out_data.inactive_ms, want.inactive_ms);
      end
    end
    out_stall <= ($urandom_range(0, 99) < recv_idle);
  end

  initial begin
    cfg_set_t s;
    tec_out_t predicted;
    tec_in_t  it;

    // Reset calibration and cleared touch state.
    s = default_settings();
    cal_min_x = s[CFG_RAW_MIN_X][11:0];
    cal_max_x = s[CFG_RAW_MAX_X][11:0];
    cal_min_y = s[CFG_RAW_MIN_Y][11:0];
    cal_max_y = s[CFG_RAW_MAX_Y][11:0];
    cal_width = s[CFG_SCREEN_WIDTH][11:0];
    cal_height = s[CFG_SCREEN_HEIGHT][11:0];
    cal_threshold = s[CFG_MOVE_THRESHOLD][7:0];
    cal_debounce = s[CFG_RELEASE_DEBOUNCE];
    pressed = 1'b0;
    release_armed = 1'b0;
    release_start = '0;
    activity_stamp = '0;
    last_x = '0;
    last_y = '0;

    // Reset calibration: notes, untouched while idle, clamps at both ends, small travel,
    // then a release that lands exactly on the debounce time.
    add_item(OP_ACTIVITY, 1'b0, 12'd0, 12'd0, 32'd100, 1'b1, KIND_NONE, 11'd0, 11'd0, 32'd0);
    add_item(OP_POLL, 1'b0, 12'hFFF, 12'hFFF, 32'd150, 1'b1, KIND_NONE, 11'd0, 11'd0, 32'd50);
    add_item(OP_POLL, 1'b1, 12'd200, 12'd240, 32'd200, 1'b1, KIND_DOWN, 11'd0, 11'd0, 32'd0);
    add_item(OP_POLL, 1'b1, 12'hFFF, 12'hFFF, 32'd210, 1'b1, KIND_MOVE, 11'd319, 11'd239,
             32'd0);
    add_item(OP_POLL, 1'b1, 12'd0, 12'd0, 32'd220, 1'b1, KIND_MOVE, 11'd0, 11'd0, 32'd0);
    add_item(OP_POLL, 1'b1, 12'd230, 12'd250, 32'd230, 1'b0, KIND_NONE, 11'd0, 11'd0, 32'd0);
    add_item(OP_ACTIVITY, 1'b1, 12'hFFF, 12'hFFF, 32'd240, 1'b1, KIND_NONE, 11'd0, 11'd0,
             32'd0);
    add_item(OP_POLL, 1'b0, 12'd0, 12'd0, 32'd1000, 1'b1, KIND_NONE, 11'd0, 11'd0, 32'd760);
    add_item(OP_POLL, 1'b0, 12'd0, 12'd0, 32'd1039, 1'b0, KIND_NONE, 11'd0, 11'd0, 32'd0);
    add_item(OP_POLL, 1'b0, 12'd0, 12'd0, 32'd1040, 1'b0, KIND_NONE, 11'd0, 11'd0, 32'd0);

    // Equal X bounds, inverted Y bounds, zero width, oversize height, zero threshold,
    // zero debounce, and a release timer that crosses the time wrap.
    s[CFG_RAW_MIN_X]        = 16'd1000;
    s[CFG_RAW_MAX_X]        = 16'd1000;
    s[CFG_RAW_MIN_Y]        = 16'd3000;
    s[CFG_RAW_MAX_Y]        = 16'd1000;
    s[CFG_SCREEN_WIDTH]     = 16'd0;
    s[CFG_SCREEN_HEIGHT]    = 16'd4095;
    s[CFG_MOVE_THRESHOLD]   = 16'd0;
    s[CFG_RELEASE_DEBOUNCE] = 16'd0;
    add_settings(s);
    add_item(OP_POLL, 1'b1, 12'd500, 12'd2000, 32'hFFFF_FFF0, 1'b0, KIND_NONE, 11'd0, 11'd0,
             32'd0);
    add_item(OP_POLL, 1'b1, 12'd500, 12'd2000, 32'hFFFF_FFF2, 1'b0, KIND_NONE, 11'd0, 11'd0,
             32'd0);
    add_item(OP_POLL, 1'b0, 12'd0, 12'd0, 32'hFFFF_FFF8, 1'b0, KIND_NONE, 11'd0, 11'd0, 32'd0);
    add_item(OP_POLL, 1'b0, 12'd0, 12'd0, 32'd5, 1'b0, KIND_NONE, 11'd0, 11'd0, 32'd0);

    // Full-range bounds, inverted Y, oversize width, zero height, largest threshold and
    // largest debounce.
    s[CFG_RAW_MIN_X]        = 16'd0;
    s[CFG_RAW_MAX_X]        = 16'd4095;
    s[CFG_RAW_MIN_Y]        = 16'd4095;
    s[CFG_RAW_MAX_Y]        = 16'd0;
    s[CFG_SCREEN_WIDTH]     = 16'd4095;
    s[CFG_SCREEN_HEIGHT]    = 16'd0;
    s[CFG_MOVE_THRESHOLD]   = 16'd255;
    s[CFG_RELEASE_DEBOUNCE] = 16'hFFFF;
    add_settings(s);
    add_item(OP_POLL, 1'b1, 12'hFFF, 12'd0, 32'd7, 1'b0, KIND_NONE, 11'd0, 11'd0, 32'd0);
    add_item(OP_POLL, 1'b1, 12'd0, 12'hFFF, 32'd8, 1'b0, KIND_NONE, 11'd0, 11'd0, 32'd0);
    add_item(OP_POLL, 1'b0, 12'd0, 12'd0, 32'd10, 1'b0, KIND_NONE, 11'd0, 11'd0, 32'd0);
    add_item(OP_POLL, 1'b0, 12'd0, 12'd0, 32'd65544, 1'b0, KIND_NONE, 11'd0, 11'd0, 32'd0);
    add_item(OP_POLL, 1'b0, 12'd0, 12'd0, 32'd65545, 1'b0, KIND_NONE, 11'd0, 11'd0, 32'd0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle = 20;
    recv_idle = 78;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        apply_settings(dir_rows[i].cfg);
      end else begin
        send_item(dir_rows[i].item);
        predicted = qualify_sample(dir_rows[i].item);
        pending_events.push_back(dir_rows[i].has_exp ? dir_rows[i].exp : predicted);
      end
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase / 2)
        0: begin send_idle = 20; recv_idle = 78; end
        1: begin send_idle = 78; recv_idle = 20; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      apply_settings(random_settings());
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        it = next_random_item();
        send_item(it);
        pending_events.push_back(qualify_sample(it));
      end
    end

    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
